[rtl/lfu_pkg.sv]
// Shared constants and types for the LFU cache controller.
// No dependencies; imported by the controller and its checker.
`timescale 1ns / 1ps

package lfu_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = 16;
	localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int USED_BITS  = $clog2(ENTRIES + 1);
	localparam int CAP_BITS   = 5;
	localparam int ADDR_BITS  = 3;
	localparam int DATA_BITS  = 32;

	localparam logic [CAP_BITS-1:0]  CAP_RESET = CAP_BITS'(16);
	localparam logic [CAP_BITS-1:0]  CAP_MAX   = CAP_BITS'(ENTRIES);
	localparam logic [ADDR_BITS-1:0] ADDR_CAPACITY = ADDR_BITS'(0);

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

endpackage

[rtl/lfu_cache_controller.sv]
// LFU cache controller: fully associative key/value store, LFU replacement, LRU tie-break.
// Depends on lfu_pkg.
`timescale 1ns / 1ps

// One access runs from the start edge to the result strobe as a scan and then an update:
// one shared key/victim compare unit walks the entries one per cycle, then
// the update state writes back the value, counts, recency ranks and valid bits. busy is high
// from the cycle after start and falls in the cycle of the result, so a new start can be taken
// in the very cycle the result shows; no new access is taken until the last one is done.
// The result (hit, read_value) is valid in the cycle in which done is high, a one-cycle
// strobe; the receiver cannot stall it and must take it then.
module lfu_cache_controller import lfu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  operation,
	input  logic [KEY_BITS-1:0]   lookup_key,
	input  logic [VALUE_BITS-1:0] write_value,
	output logic                  done,
	output logic                  hit,
	output logic [VALUE_BITS-1:0] read_value,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_BITS-1:0]  paddr,
	input  logic [DATA_BITS-1:0]  pwdata,
	output logic [DATA_BITS-1:0]  prdata,
	output logic                  pready
);

	state_t state_q;

	logic [CAP_BITS-1:0]   cap_q;
	logic [USED_BITS-1:0]  used_q;
	logic [ENTRIES-1:0]    valid_q;
	logic [KEY_BITS-1:0]   key_arr_q   [ENTRIES];
	logic [VALUE_BITS-1:0] val_arr_q   [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_arr_q   [ENTRIES];
	logic [IDX_BITS-1:0]   rank_arr_q  [ENTRIES];

	// latched access word
	logic                  op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] wval_q;

	logic [IDX_BITS-1:0]   idx_q;

	// scan results
	logic                  found_q;
	logic [IDX_BITS-1:0]   slot_q;
	logic [VALUE_BITS-1:0] m_val_q;
	logic [COUNT_BITS-1:0] m_cnt_q;
	logic [IDX_BITS-1:0]   m_rank_q;
	logic                  vhave_q;
	logic [IDX_BITS-1:0]   v_idx_q;
	logic [COUNT_BITS-1:0] v_cnt_q;
	logic [IDX_BITS-1:0]   v_rank_q;
	logic                  fhave_q;
	logic [IDX_BITS-1:0]   f_idx_q;

	logic                  done_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] rval_q;

	// ---------------- configuration port ----------------
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_CAPACITY);
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_CAPACITY) ? DATA_BITS'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[CAP_BITS-1:0];
		end
	end

	// ---------------- scan unit ----------------
	logic                  cur_valid;
	logic                  cur_match;
	logic                  cur_better;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic [IDX_BITS-1:0]   cur_rank;
	logic                  scan_last;

	assign cur_valid  = valid_q[idx_q];
	assign cur_cnt    = cnt_arr_q[idx_q];
	assign cur_rank   = rank_arr_q[idx_q];
	assign cur_match  = cur_valid && (key_arr_q[idx_q] == key_q);
	assign cur_better = cur_valid && (!vhave_q || (cur_cnt < v_cnt_q) ||
		((cur_cnt == v_cnt_q) && (cur_rank < v_rank_q)));
	assign scan_last  = (idx_q == IDX_BITS'(ENTRIES - 1));

	// ---------------- update decisions ----------------
	logic [CAP_BITS-1:0]  cap_eff;
	logic                 cap_nz;
	logic                 do_touch;
	logic                 do_evict;
	logic                 do_ins;
	logic                 dec_en;
	logic [IDX_BITS-1:0]  dec_thr;
	logic [IDX_BITS-1:0]  ins_idx;
	logic [USED_BITS-1:0] used_after;

	always_comb begin
		cap_eff  = (cap_q > CAP_MAX) ? CAP_MAX : cap_q;
		cap_nz   = (cap_eff != '0);
		do_touch = found_q && ((op_q == OP_GET) || cap_nz);
		do_ins   = (op_q == OP_PUT) && cap_nz && !found_q;
		do_evict = do_ins && vhave_q && (used_q != '0) &&
			(CAP_BITS'(used_q) >= cap_eff);
		dec_en   = do_touch || do_evict;
		dec_thr  = do_touch ? m_rank_q : v_rank_q;
		if (do_evict && !(fhave_q && (f_idx_q < v_idx_q))) begin
			ins_idx = v_idx_q;
		end else begin
			ins_idx = f_idx_q;
		end
		used_after = do_evict ? (used_q - USED_BITS'(1)) : used_q;
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
			used_q  <= '0;
			valid_q <= '0;
			found_q <= 1'b0;
			vhave_q <= 1'b0;
			fhave_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						found_q <= 1'b0;
						vhave_q <= 1'b0;
						fhave_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (cur_match && !found_q) begin
						found_q <= 1'b1;
					end
					if (cur_better) begin
						vhave_q <= 1'b1;
					end
					if (!cur_valid && !fhave_q) begin
						fhave_q <= 1'b1;
					end
					if (scan_last) begin
						state_q <= ST_UPD;
					end else begin
						idx_q <= idx_q + IDX_BITS'(1);
					end
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					// a victim slot that is refilled stays valid
					if (do_evict && (ins_idx != v_idx_q)) begin
						valid_q[v_idx_q] <= 1'b0;
					end
					if (do_ins) begin
						valid_q[ins_idx] <= 1'b1;
						used_q           <= used_after + USED_BITS'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q   <= operation;
			key_q  <= lookup_key;
			wval_q <= write_value;
		end
		if (state_q == ST_SCAN) begin
			if (cur_match && !found_q) begin
				slot_q   <= idx_q;
				m_val_q  <= val_arr_q[idx_q];
				m_cnt_q  <= cur_cnt;
				m_rank_q <= cur_rank;
			end
			if (cur_better) begin
				v_idx_q  <= idx_q;
				v_cnt_q  <= cur_cnt;
				v_rank_q <= cur_rank;
			end
			if (!cur_valid && !fhave_q) begin
				f_idx_q <= idx_q;
			end
		end
		if (state_q == ST_UPD) begin
			hit_q  <= found_q;
			rval_q <= (found_q && (op_q == OP_GET)) ? m_val_q : '0;
			// close the gap left by the touched or evicted entry
			for (int i = 0; i < ENTRIES; i++) begin
				if (dec_en && valid_q[i] && (rank_arr_q[i] > dec_thr) &&
					!(do_evict && (IDX_BITS'(i) == v_idx_q))) begin
					rank_arr_q[i] <= rank_arr_q[i] - IDX_BITS'(1);
				end
			end
			if (do_touch) begin
				if (m_cnt_q != '1) begin
					cnt_arr_q[slot_q] <= m_cnt_q + COUNT_BITS'(1);
				end
				rank_arr_q[slot_q] <= IDX_BITS'(used_q - USED_BITS'(1));
				if (op_q == OP_PUT) begin
					val_arr_q[slot_q] <= wval_q;
				end
			end
			if (do_ins) begin
				key_arr_q[ins_idx]  <= key_q;
				val_arr_q[ins_idx]  <= wval_q;
				cnt_arr_q[ins_idx]  <= COUNT_BITS'(1);
				rank_arr_q[ins_idx] <= IDX_BITS'(used_after);
			end
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign hit        = hit_q;
	assign read_value = rval_q;

endmodule

[rtl/lfu_checker.sv]
// Port-level checker for the LFU cache controller, bound into the controller module.
// Depends on lfu_pkg and lfu_cache_controller.
`timescale 1ns / 1ps

module lfu_checker import lfu_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic                  hit,
	input logic [VALUE_BITS-1:0] read_value
);

	// an accepted word keeps the block busy in the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted word");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_no_done_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result right after accepted word");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> read_value == '0)
		else $error("nonzero read value on miss");

endmodule

bind lfu_cache_controller lfu_checker u_lfu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.hit        (hit),
	.read_value (read_value)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// Testbench for lfu_cache_controller: directed and random get/put traffic with
// every reply checked against an in-bench model of the LFU store with LRU tie-break.
// Depends on lfu_pkg and the controller RTL.

module testbench import lfu_pkg::*; ();

	typedef struct packed {
		logic                  hit;
		logic [VALUE_BITS-1:0] value;
	} reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  operation;
	logic [KEY_BITS-1:0]   lookup_key;
	logic [VALUE_BITS-1:0] write_value;
	logic                  done;
	logic                  hit;
	logic [VALUE_BITS-1:0] read_value;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_BITS-1:0]  paddr;
	logic [DATA_BITS-1:0]  pwdata;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;

	// Store model: keys, values, use counts and recency ages per slot
	logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
	logic [VALUE_BITS-1:0] slot_value [ENTRIES];
	bit                    slot_live  [ENTRIES];
	logic [COUNT_BITS-1:0] slot_uses  [ENTRIES];
	int                    slot_age   [ENTRIES];
	int                    live_count;
	logic [CAP_BITS-1:0]   capacity_setting;

	reply_t                pending_replies [$];
	logic [KEY_BITS-1:0]   key_pool [20];
	int                    errors;
	bit                    gaps_on;

	lfu_cache_controller DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.done        (done),
		.hit         (hit),
		.read_value  (read_value),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	task automatic note_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		errors++;
		if (errors <= 200)
			$display("%0t ns: %s mismatch: expected %h, actual %h", $time, field, want, got);
	endtask

	// Raise the use count (saturating) and make slot s the most recent.
	function automatic void promote(int s);
		int i;
		if (slot_uses[s] != '1)
			slot_uses[s] = slot_uses[s] + 1'b1;
		for (i = 0; i < ENTRIES; i++)
			if (slot_live[i] && slot_age[i] > slot_age[s])
				slot_age[i]--;
		slot_age[s] = live_count - 1;
	endfunction

	function automatic reply_t cache_access(input logic op, input logic [KEY_BITS-1:0] key,
			input logic [VALUE_BITS-1:0] val);
		reply_t r;
		int     i;
		int     s;
		int     victim;
		int     limit;
		bit     found;
		r = '0;
		found = 1'b0;
		s = 0;
		victim = -1;
		limit = (capacity_setting > ENTRIES) ? ENTRIES : int'(capacity_setting);
		for (i = 0; i < ENTRIES; i++)
			if (!found && slot_live[i] && slot_key[i] == key) begin
				found = 1'b1;
				s = i;
			end
		r.hit = found;
		if (op == OP_GET) begin
			if (found) begin
				r.value = slot_value[s];
				promote(s);
			end
		end else if (limit != 0) begin
			if (found) begin
				slot_value[s] = val;
				promote(s);
			end else begin
				// evict lowest count, oldest among equal counts
				if (live_count >= limit) begin
					for (i = 0; i < ENTRIES; i++)
						if (slot_live[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
								(slot_uses[i] == slot_uses[victim] &&
								slot_age[i] < slot_age[victim])))
							victim = i;
					if (victim >= 0) begin
						slot_live[victim] = 1'b0;
						for (i = 0; i < ENTRIES; i++)
							if (slot_live[i] && slot_age[i] > slot_age[victim])
								slot_age[i]--;
						live_count--;
					end
				end
				s = -1;
				for (i = 0; i < ENTRIES; i++)
					if (s < 0 && !slot_live[i])
						s = i;
				if (s >= 0) begin
					slot_live[s] = 1'b1;
					slot_key[s] = key;
					slot_value[s] = val;
					slot_uses[s] = COUNT_BITS'(1);
					slot_age[s] = live_count;
					live_count++;
				end
			end
		end
		return r;
	endfunction

	task automatic send_access(input logic op, input logic [KEY_BITS-1:0] key,
			input logic [VALUE_BITS-1:0] val);
		// idle only once the block is ready, so the gap really holds off words
		if (gaps_on && $urandom_range(99) < 30) begin
			@(negedge clk);
			start = 1'b0;
			while (busy)
				@(negedge clk);
			repeat ($urandom_range(13, 1)) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		operation = op;
		lookup_key = key;
		write_value = val;
		do @(posedge clk); while (busy);
		pending_replies.push_back(cache_access(op, key, val));
	endtask

	// Drop start, then let every outstanding word come back.
	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 2) @(posedge clk);
	endtask

	task automatic apb_cycle(input logic wr, input logic [DATA_BITS-1:0] wdata,
			output logic [DATA_BITS-1:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = ADDR_CAPACITY;
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic check_capacity_reg();
		logic [DATA_BITS-1:0] rd;
		apb_cycle(1'b0, '0, rd);
		if (rd !== DATA_BITS'(capacity_setting))
			note_mismatch("capacity_in_use", 64'(capacity_setting), 64'(rd));
	endtask

	task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
		logic [DATA_BITS-1:0] ignored;
		wait_idle();
		apb_cycle(1'b1, DATA_BITS'(cap), ignored);
		capacity_setting = cap;
		check_capacity_reg();
	endtask

	always @(posedge clk) begin : check_reply
		reply_t want;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				note_mismatch("unrequested reply", '0, 64'({hit, read_value}));
			end else begin
				want = pending_replies.pop_front();
				if (hit !== want.hit)
					note_mismatch("hit", 64'(want.hit), 64'(hit));
				if (read_value !== want.value)
					note_mismatch("read_value", 64'(want.value), 64'(read_value));
			end
		end
	end

	task automatic test_register_reset();
		check_capacity_reg();
	endtask

	task automatic test_empty_and_extremes();
		send_access(OP_GET, '0, '1);
		send_access(OP_GET, '1, '0);
		send_access(OP_PUT, '0, '1);
		send_access(OP_PUT, '1, '0);
		send_access(OP_PUT, '0, 32'h1234_5678);
		send_access(OP_GET, '0, '0);
		send_access(OP_GET, '1, '1);
		send_access(OP_GET, 32'h0000_0001, '0);
	endtask

	// Puts are ignored, gets still hit what is stored.
	task automatic test_capacity_zero();
		set_capacity('0);
		send_access(OP_PUT, '0, 32'hDEAD_BEEF);
		send_access(OP_PUT, 32'h0000_0007, 32'h0000_0077);
		send_access(OP_GET, 32'h0000_0007, '0);
		send_access(OP_GET, '0, '0);
	endtask

	task automatic test_lfu_eviction();
		set_capacity(CAP_BITS'(3));
		send_access(OP_PUT, 32'h0000_0010, 32'hAAAA_0010);
		// two entries share the lowest count: the older one goes
		send_access(OP_PUT, 32'h0000_0020, 32'hAAAA_0020);
		send_access(OP_GET, 32'h0000_0020, '0);
		send_access(OP_PUT, 32'h0000_0030, 32'hAAAA_0030);
		send_access(OP_GET, '1, '0);
		send_access(OP_GET, 32'h0000_0020, '0);
	endtask

	// A heavily used entry outlives newer, rarely used ones; no idling meanwhile.
	task automatic test_frequent_entry_kept();
		set_capacity(CAP_BITS'(2));
		send_access(OP_PUT, 32'hA5A5_0001, 32'h5A5A_0001);
		gaps_on = 1'b0;
		repeat (40) send_access(OP_GET, 32'hA5A5_0001, '0);
		gaps_on = 1'b1;
		send_access(OP_PUT, 32'hA5A5_0002, 32'h5A5A_0002);
		send_access(OP_PUT, 32'hA5A5_0003, 32'h5A5A_0003);
		send_access(OP_GET, 32'hA5A5_0001, '0);
	endtask

	task automatic test_random_traffic();
		int                  caps [7];
		int                  p;
		int                  pick;
		logic [KEY_BITS-1:0] key;
		caps = '{31, 4, 0, 1, 16, 9, -1};
		foreach (key_pool[i])
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (p = 0; p < 7; p++) begin
			set_capacity(caps[p] < 0 ? CAP_BITS'($urandom_range(31)) : CAP_BITS'(caps[p]));
			repeat (52) begin
				pick = $urandom_range(99);
				if (pick < 75)
					key = key_pool[$urandom_range(19)];
				else if (pick < 85)
					key = KEY_BITS'($urandom_range(3));
				else
					key = $urandom;
				send_access(($urandom_range(99) < 45) ? OP_PUT : OP_GET, key, $urandom);
			end
		end
	endtask

	initial begin
		start = 1'b0;
		operation = OP_GET;
		lookup_key = '0;
		write_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_CAPACITY;
		pwdata = '0;
		foreach (slot_live[i])
			slot_live[i] = 1'b0;
		live_count = 0;
		capacity_setting = CAP_RESET;
		errors = 0;
		gaps_on = 1'b1;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_reset();
		test_empty_and_extremes();
		test_capacity_zero();
		test_lfu_eviction();
		test_frequent_entry_kept();
		test_random_traffic();
		wait_idle();

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
